/* design/ir_aircon_frame_transmitter_core_macros.svh */
// assertion helpers for the transmitter slot engine
// both sample on clk_i and stay quiet while rst_ni is low
`ifndef IR_AIRCON_FRAME_TRANSMITTER_CORE_MACROS_SVH
`define IR_AIRCON_FRAME_TRANSMITTER_CORE_MACROS_SVH

// same-cycle implication
`define AFT_ASSERT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define AFT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/ir_aft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ir_aft_pkg;

  localparam int PeriodW  = 12;
  localparam int CodeW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;
  localparam int ButtonW  = 3;
  localparam int RomIdxW  = 5;

  localparam logic [CodeW-1:0]   TempReset  = 8'h08;
  localparam logic [CodeW-1:0]   CheckReset = 8'hD4;
  localparam logic [CodeW-1:0]   OffCheck   = 8'hB4;
  localparam logic [RomIdxW-1:0] TempByte   = 5'd7;

  localparam logic [PeriodW-1:0] LeaderPeriodReset  = 12'd600;
  localparam logic [PeriodW-1:0] LeaderMarkReset    = 12'd400;
  localparam logic [PeriodW-1:0] OnePeriodReset     = 12'd200;
  localparam logic [PeriodW-1:0] ZeroPeriodReset    = 12'd100;
  localparam logic [PeriodW-1:0] BitMarkReset       = 12'd50;
  localparam logic [PeriodW-1:0] TrailerPeriodReset = 12'd212;
  localparam logic [CodeW-1:0]   CheckMinReset      = 8'd206;
  localparam logic [CodeW-1:0]   CheckMaxReset      = 8'd220;

  typedef enum logic {
    OP_BUTTON  = 1'b0,
    OP_ELAPSED = 1'b1
  } opcode_e;

  typedef enum logic [ButtonW-1:0] {
    BTN_NONE   = 3'd0,
    BTN_ON     = 3'd1,
    BTN_WARMER = 3'd2,
    BTN_COOLER = 3'd3,
    BTN_OFF    = 3'd4
  } button_e;

  typedef enum logic [1:0] {
    KIND_LEADER  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_TRAILER = 2'd2,
    KIND_STOP    = 2'd3
  } slot_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEADER_PERIOD  = 3'd0,
    REG_LEADER_MARK    = 3'd1,
    REG_ONE_PERIOD     = 3'd2,
    REG_ZERO_PERIOD    = 3'd3,
    REG_BIT_MARK       = 3'd4,
    REG_TRAILER_PERIOD = 3'd5,
    REG_CHECK_MIN      = 3'd6,
    REG_CHECK_MAX      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PeriodW-1:0] leader_period;
    logic [PeriodW-1:0] leader_mark;
    logic [PeriodW-1:0] one_period;
    logic [PeriodW-1:0] zero_period;
    logic [PeriodW-1:0] bit_mark;
    logic [PeriodW-1:0] trailer_period;
    logic [CodeW-1:0]   check_min;
    logic [CodeW-1:0]   check_max;
  } cfg_t;

  typedef struct packed {
    opcode_e            opcode;
    logic [ButtonW-1:0] button;
  } item_t;

  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] mark;
    slot_kind_e         kind;
    logic               stop;
  } result_t;

  // fixed frame bytes; the checksum and temperature bytes are patched in later
  function automatic logic [CodeW-1:0] frame_rom(input logic off,
                                                 input logic [RomIdxW-1:0] idx);
    logic [CodeW-1:0] val;
    case (idx)
      5'd0:    val = 8'h23;
      5'd1:    val = 8'hCB;
      5'd2:    val = 8'h26;
      5'd3:    val = 8'h01;
      5'd4:    val = 8'h00;
      5'd5:    val = off ? 8'h00 : 8'h20;
      5'd6:    val = 8'h18;
      5'd7:    val = 8'h08;
      5'd8:    val = 8'h36;
      5'd9:    val = 8'h49;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

/* design/ir_aft_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface ir_aft_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [ir_aft_pkg::ButtonW-1:0]  button;

  modport source (output valid, output opcode, output button, input ready);
  modport sink (input valid, input opcode, input button, output ready);
endinterface
`default_nettype wire

/* design/ir_aft_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface ir_aft_out_if;
  logic                            valid;
  logic                            ready;
  logic [ir_aft_pkg::PeriodW-1:0]  slot_period;
  logic [ir_aft_pkg::PeriodW-1:0]  slot_mark;
  logic [1:0]                      slot_kind;
  logic                            carrier_stop;

  modport source (output valid, output slot_period, output slot_mark, output slot_kind,
                  output carrier_stop, input ready);
  modport sink (input valid, input slot_period, input slot_mark, input slot_kind,
                input carrier_stop, output ready);
endinterface
`default_nettype wire

/* design/ir_aft_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface ir_aft_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ir_aft_pkg::CfgIdxW-1:0]   index;
  logic [ir_aft_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/ir_aft_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module ir_aft_cfg_regs (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  ir_aft_cfg_if.sink           cfg_i,
  output ir_aft_pkg::cfg_t     cfg_o
);

  ir_aft_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (ir_aft_pkg::cfg_reg_e'(cfg_i.index))
        ir_aft_pkg::REG_LEADER_PERIOD:  cfg_d.leader_period  = cfg_i.data;
        ir_aft_pkg::REG_LEADER_MARK:    cfg_d.leader_mark    = cfg_i.data;
        ir_aft_pkg::REG_ONE_PERIOD:     cfg_d.one_period     = cfg_i.data;
        ir_aft_pkg::REG_ZERO_PERIOD:    cfg_d.zero_period    = cfg_i.data;
        ir_aft_pkg::REG_BIT_MARK:       cfg_d.bit_mark       = cfg_i.data;
        ir_aft_pkg::REG_TRAILER_PERIOD: cfg_d.trailer_period = cfg_i.data;
        ir_aft_pkg::REG_CHECK_MIN:      cfg_d.check_min = cfg_i.data[ir_aft_pkg::CodeW-1:0];
        ir_aft_pkg::REG_CHECK_MAX:      cfg_d.check_max = cfg_i.data[ir_aft_pkg::CodeW-1:0];
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_period  <= ir_aft_pkg::LeaderPeriodReset;
      cfg_q.leader_mark    <= ir_aft_pkg::LeaderMarkReset;
      cfg_q.one_period     <= ir_aft_pkg::OnePeriodReset;
      cfg_q.zero_period    <= ir_aft_pkg::ZeroPeriodReset;
      cfg_q.bit_mark       <= ir_aft_pkg::BitMarkReset;
      cfg_q.trailer_period <= ir_aft_pkg::TrailerPeriodReset;
      cfg_q.check_min      <= ir_aft_pkg::CheckMinReset;
      cfg_q.check_max      <= ir_aft_pkg::CheckMaxReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* design/ir_aft_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module ir_aft_in_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  ir_aft_in_if.sink            in_i,
  input  wire                  take_i,
  output logic                 item_valid_o,
  output ir_aft_pkg::item_t    item_o
);

  logic              valid_q, valid_d;
  ir_aft_pkg::item_t item_q;
  logic              load;

  // a held request leaves in the same cycle a new one comes in
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.opcode <= ir_aft_pkg::opcode_e'(in_i.opcode);
      item_q.button <= in_i.button;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

/* design/ir_aft_slot_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "ir_aircon_frame_transmitter_core_macros.svh"
module ir_aft_slot_engine #(
  parameter int FRAME_BYTES  = 18,
  parameter int REPEAT_COUNT = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  item_valid_i,
  input  ir_aft_pkg::item_t    item_i,
  input  ir_aft_pkg::cfg_t     cfg_i,
  output logic                 take_o,
  ir_aft_out_if.source         res_o
);

  localparam int LastSlot = 8 * FRAME_BYTES + 1;
  localparam int SlotW    = $clog2(LastSlot + 1);
  localparam int CodeW    = ir_aft_pkg::CodeW;
  localparam int RomIdxW  = ir_aft_pkg::RomIdxW;

  logic             busy_q, busy_d;
  logic             off_q, off_d;
  logic             rep_q, rep_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [CodeW-1:0] temp_q, temp_d;
  logic [CodeW-1:0] check_q, check_d;

  logic                out_valid_q, out_valid_d;
  ir_aft_pkg::result_t res_q, res;
  logic                emit, stop;

  logic [SlotW-1:0]   bit_sel;
  logic [RomIdxW-1:0] byte_idx;
  logic [CodeW-1:0]   frame_byte;
  logic               bit_val;

  assign take_o = item_valid_i && (!out_valid_q || res_o.ready);

  // state update for one request
  always_comb begin
    busy_d  = busy_q;
    off_d   = off_q;
    rep_d   = rep_q;
    slot_d  = slot_q;
    temp_d  = temp_q;
    check_d = check_q;
    emit    = 1'b0;
    stop    = 1'b0;
    case (item_i.opcode)
      ir_aft_pkg::OP_BUTTON: begin
        if (!busy_q) begin
          case (item_i.button)
            ir_aft_pkg::BTN_ON, ir_aft_pkg::BTN_WARMER, ir_aft_pkg::BTN_COOLER,
            ir_aft_pkg::BTN_OFF: begin
              emit   = 1'b1;
              busy_d = 1'b1;
              rep_d  = 1'b0;
              slot_d = '0;
              off_d  = (item_i.button == ir_aft_pkg::BTN_OFF);
              if (item_i.button == ir_aft_pkg::BTN_WARMER && check_q < cfg_i.check_max) begin
                check_d = check_q + 8'd1;
                temp_d  = temp_q + 8'd1;
              end else if (item_i.button == ir_aft_pkg::BTN_COOLER &&
                           check_q > cfg_i.check_min) begin
                check_d = check_q - 8'd1;
                temp_d  = temp_q - 8'd1;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      ir_aft_pkg::OP_ELAPSED: begin
        if (busy_q) begin
          emit = 1'b1;
          if (slot_q < SlotW'(LastSlot)) begin
            slot_d = slot_q + SlotW'(1);
          end else if (int'(rep_q) + 1 < REPEAT_COUNT) begin
            rep_d  = 1'b1;
            slot_d = '0;
          end else begin
            busy_d = 1'b0;
            rep_d  = 1'b0;
            slot_d = '0;
            stop   = 1'b1;
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // bit of the frame for the next data slot; checksum byte wins over the temperature byte
  assign bit_sel  = slot_d - SlotW'(1);
  assign byte_idx = RomIdxW'(bit_sel >> 3);

  always_comb begin
    if (byte_idx == RomIdxW'(FRAME_BYTES - 1)) begin
      frame_byte = off_d ? ir_aft_pkg::OffCheck : check_d;
    end else if (!off_d && byte_idx == ir_aft_pkg::TempByte) begin
      frame_byte = temp_d;
    end else begin
      frame_byte = ir_aft_pkg::frame_rom(off_d, byte_idx);
    end
  end

  assign bit_val = frame_byte[bit_sel[2:0]];

  always_comb begin
    if (stop) begin
      res.period = '0;
      res.mark   = '0;
      res.kind   = ir_aft_pkg::KIND_STOP;
    end else if (slot_d == '0) begin
      res.period = cfg_i.leader_period;
      res.mark   = cfg_i.leader_mark;
      res.kind   = ir_aft_pkg::KIND_LEADER;
    end else if (slot_d >= SlotW'(LastSlot)) begin
      res.period = cfg_i.trailer_period;
      res.mark   = cfg_i.bit_mark;
      res.kind   = ir_aft_pkg::KIND_TRAILER;
    end else begin
      res.period = bit_val ? cfg_i.one_period : cfg_i.zero_period;
      res.mark   = cfg_i.bit_mark;
      res.kind   = ir_aft_pkg::KIND_DATA;
    end
    res.stop = stop;
  end

  always_comb begin
    out_valid_d = out_valid_q && !res_o.ready;
    if (take_o) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      off_q       <= 1'b0;
      rep_q       <= 1'b0;
      slot_q      <= '0;
      temp_q      <= ir_aft_pkg::TempReset;
      check_q     <= ir_aft_pkg::CheckReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        busy_q  <= busy_d;
        off_q   <= off_d;
        rep_q   <= rep_d;
        slot_q  <= slot_d;
        temp_q  <= temp_d;
        check_q <= check_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      res_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.slot_period  = res_q.period;
  assign res_o.slot_mark    = res_q.mark;
  assign res_o.slot_kind    = res_q.kind;
  assign res_o.carrier_stop = res_q.stop;

  `AFT_ASSERT(idle_counters_clear, !busy_q, slot_q == '0 && rep_q == 1'b0, "idle with slot state set")
  `AFT_ASSERT(slot_in_frame, busy_q, slot_q <= SlotW'(LastSlot), "slot index past trailer")
  `AFT_ASSERT(hold_on_stall, out_valid_q && !res_o.ready, !take_o, "request taken while result stalled")
  `AFT_ASSERT_NEXT(stop_goes_idle, take_o && stop, !busy_q && out_valid_q && res_o.carrier_stop, "stop did not end transmission")

endmodule
`default_nettype wire

/* design/ir_aircon_frame_transmitter_core.sv */
// path: a request is registered at the input stage, and its slot result is registered in
//   the output register once the slot engine takes it, which waits while a result stalls
// throughput: one request per cycle when not stalled; slot and bit select are combinational
// reset: clears busy, slot and repeat counters, loads temperature 0x08, checksum 0xD4
//   and the default slot timings; no clearing pass, requests taken right after reset
`timescale 1ns / 1ps
`default_nettype none
module ir_aircon_frame_transmitter_core #(
  parameter int FRAME_BYTES  = 18,
  parameter int REPEAT_COUNT = 2
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  ir_aft_in_if.sink     in_i,
  ir_aft_cfg_if.sink    cfg_i,
  ir_aft_out_if.source  res_o
);

  ir_aft_pkg::cfg_t  cfg;
  ir_aft_pkg::item_t item;
  logic              item_valid;
  logic              take;

  ir_aft_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ir_aft_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ir_aft_slot_engine #(
    .FRAME_BYTES  (FRAME_BYTES),
    .REPEAT_COUNT (REPEAT_COUNT)
  ) u_slot_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .cfg_i        (cfg),
    .take_o       (take),
    .res_o        (res_o)
  );

endmodule
`default_nettype wire

/* tb/sv/ir_aircon_frame_transmitter_core_tb.sv */
`timescale 1ns / 1ps
module ir_aircon_frame_transmitter_core_tb;
  import ir_aft_pkg::*;

  localparam int NBYTES      = 18;
  localparam int NREPEATS    = 2;
  localparam int LAST_SLOT   = 8 * NBYTES + 1;
  // elapsed requests from the first leader to the stop result
  localparam int TX_SLOTS    = NREPEATS * (8 * NBYTES + 2);
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [CodeW-1:0] ON_FRAME [0:9] = '{
    8'h23, 8'hCB, 8'h26, 8'h01, 8'h00, 8'h20, 8'h18, 8'h08, 8'h36, 8'h49
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ir_aft_in_if  in_if ();
  ir_aft_cfg_if cfg_if ();
  ir_aft_out_if res_if ();

  ir_aircon_frame_transmitter_core #(
    .FRAME_BYTES (NBYTES),
    .REPEAT_COUNT(NREPEATS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  // transmitter state as predicted
  cfg_t             tx_cfg;
  logic [CodeW-1:0] tx_temp;
  logic [CodeW-1:0] tx_check;
  logic             tx_busy;
  logic             tx_off;
  int unsigned      tx_rep;
  int unsigned      tx_slot;

  item_t       button_q [$];
  result_t     slot_q [$];
  item_t       in_held;
  int unsigned pend_slots;
  int unsigned live_items;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned err_count;
  int unsigned cycle_count;
  bit          calm;

  function automatic logic [CodeW-1:0] frame_byte(input int unsigned idx);
    logic [CodeW-1:0] b;
    b = (idx < 10) ? ON_FRAME[idx] : 8'h00;
    if (tx_off && idx == 5) b = 8'h00;
    if (!tx_off && idx == TempByte) b = tx_temp;
    // checksum byte wins over anything else at the end of the frame
    if (idx == NBYTES - 1) b = tx_off ? OffCheck : tx_check;
    return b;
  endfunction

  function automatic result_t slot_now();
    result_t          r;
    int unsigned      bit_no;
    logic [CodeW-1:0] b;
    r.stop = 1'b0;
    r.mark = tx_cfg.bit_mark;
    if (tx_slot == 0) begin
      r.period = tx_cfg.leader_period;
      r.mark   = tx_cfg.leader_mark;
      r.kind   = KIND_LEADER;
    end else if (tx_slot >= LAST_SLOT) begin
      r.period = tx_cfg.trailer_period;
      r.kind   = KIND_TRAILER;
    end else begin
      bit_no   = tx_slot - 1;
      b        = frame_byte(bit_no / 8);
      r.period = b[bit_no % 8] ? tx_cfg.one_period : tx_cfg.zero_period;
      r.kind   = KIND_DATA;
    end
    return r;
  endfunction

  task automatic predict_slot(input item_t it);
    if (it.opcode == OP_BUTTON) begin
      if (!tx_busy && it.button >= BTN_ON && it.button <= BTN_OFF) begin
        if (it.button == BTN_WARMER && tx_check < tx_cfg.check_max) begin
          tx_check = tx_check + 8'd1;
          tx_temp  = tx_temp + 8'd1;
        end else if (it.button == BTN_COOLER && tx_check > tx_cfg.check_min) begin
          tx_check = tx_check - 8'd1;
          tx_temp  = tx_temp - 8'd1;
        end
        tx_off  = (it.button == BTN_OFF);
        tx_busy = 1'b1;
        tx_rep  = 0;
        tx_slot = 0;
        slot_q.push_back(slot_now());
      end
    end else if (tx_busy) begin
      if (tx_slot < LAST_SLOT) begin
        tx_slot++;
        slot_q.push_back(slot_now());
      end else if (tx_rep + 1 < NREPEATS) begin
        tx_rep++;
        tx_slot = 0;
        slot_q.push_back(slot_now());
      end else begin
        tx_busy = 1'b0;
        tx_rep  = 0;
        tx_slot = 0;
        slot_q.push_back(result_t'{period: '0, mark: '0, kind: KIND_STOP, stop: 1'b1});
      end
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.opcode <= OP_BUTTON;
      in_if.button <= BTN_NONE;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_slot(in_held);
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(9) == 0) begin
          in_gap = $urandom_range(7);
          in_if.valid <= 1'b0;
        end else if (button_q.size() > 0) begin
          in_held = button_q.pop_front();
          in_if.valid  <= 1'b1;
          in_if.opcode <= in_held.opcode;
          in_if.button <= in_held.button;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (slot_q.size() == 0) begin
          $error("unexpected slot result: period %0d mark %0d kind %0d stop %0d",
                 res_if.slot_period, res_if.slot_mark, res_if.slot_kind,
                 res_if.carrier_stop);
          err_count++;
        end else begin
          e = slot_q.pop_front();
          if (res_if.slot_period !== e.period) begin
            $error("slot_period: expected %0d, got %0d", e.period, res_if.slot_period);
            err_count++;
          end
          if (res_if.slot_mark !== e.mark) begin
            $error("slot_mark: expected %0d, got %0d", e.mark, res_if.slot_mark);
            err_count++;
          end
          if (res_if.slot_kind !== e.kind) begin
            $error("slot_kind: expected %0d, got %0d", e.kind, res_if.slot_kind);
            err_count++;
          end
          if (res_if.carrier_stop !== e.stop) begin
            $error("carrier_stop: expected %0d, got %0d", e.stop, res_if.carrier_stop);
            err_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(9) == 0) begin
        out_gap = $urandom_range(7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_item(input opcode_e op, input logic [ButtonW-1:0] btn);
    item_t it;
    it.opcode = op;
    it.button = btn;
    button_q.push_back(it);
    if (op == OP_BUTTON) begin
      if (pend_slots == 0 && btn >= BTN_ON && btn <= BTN_OFF) begin
        pend_slots = TX_SLOTS;
        live_items++;
      end
    end else if (pend_slots > 0) begin
      pend_slots--;
      live_items++;
    end
  endtask

  task automatic finish_frame();
    while (pend_slots > 0) queue_item(OP_ELAPSED, BTN_NONE);
  endtask

  task automatic gen_phase(input int unsigned n, input int unsigned cool_pct);
    int unsigned      stop_at;
    int unsigned      r;
    int unsigned      pick;
    logic [ButtonW-1:0] b;
    stop_at = live_items + n;
    while (live_items < stop_at) begin
      r = $urandom_range(99);
      if (pend_slots == 0) begin
        if (r < 8) begin
          queue_item(OP_ELAPSED, ButtonW'($urandom));
        end else if (r < 16) begin
          // unknown codes above off, or none
          pick = $urandom_range(3);
          b = (pick == 0) ? BTN_NONE : ButtonW'(BTN_OFF) + ButtonW'(pick);
          queue_item(OP_BUTTON, b);
        end else begin
          if ($urandom_range(99) < cool_pct) b = BTN_COOLER;
          else b = ButtonW'($urandom_range(int'(BTN_OFF), int'(BTN_ON)));
          queue_item(OP_BUTTON, b);
        end
      end else if (r < 5) begin
        queue_item(OP_BUTTON, ButtonW'($urandom));
      end else begin
        queue_item(OP_ELAPSED, ButtonW'($urandom));
      end
    end
    finish_frame();
  endtask

  // returns at a rising edge once every request is taken and every slot is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (button_q.size() != 0 || in_if.valid === 1'b1 || slot_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i);
    while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_LEADER_PERIOD:  tx_cfg.leader_period  = val;
      REG_LEADER_MARK:    tx_cfg.leader_mark    = val;
      REG_ONE_PERIOD:     tx_cfg.one_period     = val;
      REG_ZERO_PERIOD:    tx_cfg.zero_period    = val;
      REG_BIT_MARK:       tx_cfg.bit_mark       = val;
      REG_TRAILER_PERIOD: tx_cfg.trailer_period = val;
      REG_CHECK_MIN:      tx_cfg.check_min      = val[CodeW-1:0];
      REG_CHECK_MAX:      tx_cfg.check_max      = val[CodeW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CfgDataW-1:0] lp, input logic [CfgDataW-1:0] lm,
                           input logic [CfgDataW-1:0] op, input logic [CfgDataW-1:0] zp,
                           input logic [CfgDataW-1:0] bm, input logic [CfgDataW-1:0] tp,
                           input logic [CfgDataW-1:0] cmin,
                           input logic [CfgDataW-1:0] cmax);
    write_reg(REG_LEADER_PERIOD, lp);
    write_reg(REG_LEADER_MARK, lm);
    write_reg(REG_ONE_PERIOD, op);
    write_reg(REG_ZERO_PERIOD, zp);
    write_reg(REG_BIT_MARK, bm);
    write_reg(REG_TRAILER_PERIOD, tp);
    write_reg(REG_CHECK_MIN, cmin);
    write_reg(REG_CHECK_MAX, cmax);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_regs();
    write_all(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
              CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
              {4'($urandom), tx_check - CodeW'($urandom_range(2))},
              {4'($urandom), tx_check + CodeW'($urandom_range(2))});
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_LEADER_PERIOD;
    cfg_if.data  = '0;
    tx_cfg = '{leader_period: LeaderPeriodReset, leader_mark: LeaderMarkReset,
               one_period: OnePeriodReset, zero_period: ZeroPeriodReset,
               bit_mark: BitMarkReset, trailer_period: TrailerPeriodReset,
               check_min: CheckMinReset, check_max: CheckMaxReset};
    tx_temp     = TempReset;
    tx_check    = CheckReset;
    tx_busy     = 1'b0;
    tx_off      = 1'b0;
    tx_rep      = 0;
    tx_slot     = 0;
    pend_slots  = 0;
    live_items  = 0;
    err_count   = 0;
    cycle_count = 0;
    calm        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ignored requests while idle, then an on frame with buttons pressed while busy, then an off frame
    queue_item(OP_ELAPSED, BTN_NONE);
    queue_item(OP_BUTTON, BTN_NONE);
    queue_item(OP_BUTTON, ButtonW'(5));
    queue_item(OP_BUTTON, ButtonW'(6));
    queue_item(OP_BUTTON, ButtonW'(7));
    queue_item(OP_BUTTON, BTN_ON);
    queue_item(OP_ELAPSED, BTN_NONE);
    queue_item(OP_BUTTON, BTN_WARMER);
    queue_item(OP_BUTTON, BTN_COOLER);
    queue_item(OP_BUTTON, BTN_OFF);
    queue_item(OP_BUTTON, BTN_ON);
    finish_frame();
    queue_item(OP_ELAPSED, ButtonW'(7));
    queue_item(OP_BUTTON, BTN_OFF);
    finish_frame();
    wait_drained();

    // widest timings; checksum limits that block both steps
    write_all(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hF00);
    queue_item(OP_BUTTON, BTN_COOLER);
    finish_frame();
    wait_drained();

    // zero timings; limits wide open so warmer steps both codes
    write_all(12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'hF00, 12'h0FF);
    queue_item(OP_BUTTON, BTN_WARMER);
    finish_frame();
    wait_drained();

    random_regs();
    calm = 1'b1;
    gen_phase(1, 50);
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/ir_aft_pkg.sv
design/ir_aft_in_if.sv
design/ir_aft_out_if.sv
design/ir_aft_cfg_if.sv
design/ir_aft_cfg_regs.sv
design/ir_aft_in_stage.sv
design/ir_aft_slot_engine.sv
design/ir_aircon_frame_transmitter_core.sv
tb/sv/ir_aircon_frame_transmitter_core_tb.sv
